FILE: src/sphere_lambert_diffuse_cosine_assert.svh
// assertion macros for the diffuse cosine block
// included by the top level, which supplies clock and reset names
`ifndef SPHERE_LAMBERT_DIFFUSE_COSINE_ASSERT_SVH
`define SPHERE_LAMBERT_DIFFUSE_COSINE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SLDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SLDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sldc_pkg.sv
// shared types and constants for the sphere diffuse cosine pipeline
// no dependencies
`default_nettype none
package sldc_pkg;

  localparam int RESULT_FRAC_BITS = 16;
  localparam int RES_W            = RESULT_FRAC_BITS + 1;
  localparam int FRONT_STAGES     = 4;
  localparam int DOT_STAGES       = 2;
  localparam int ROOT_STAGES      = 32;
  localparam int DIV_STAGES       = RESULT_FRAC_BITS + 2;

  typedef struct packed {
    logic [31:0]        hit_distance;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } sldc_in_t;

  typedef struct packed {
    logic [RES_W-1:0] diffuse_factor;
    logic             degenerate;
  } sldc_out_t;

  // block-scaled normal and light vector
  typedef struct packed {
    logic             deg;
    logic [2:0]       nsg;
    logic [2:0]       lsg;
    logic [2:0][29:0] nm;
    logic [2:0][29:0] lm;
  } sldc_vec_t;

  typedef struct packed {
    logic               deg;
    logic signed [63:0] dot;
    logic [63:0]        n2;
    logic [63:0]        l2;
  } sldc_sums_t;

  // two square roots in flight plus the dot product riding along
  typedef struct packed {
    logic               deg;
    logic signed [63:0] dot;
    logic [63:0]        xn;
    logic [63:0]        rn;
    logic [63:0]        xl;
    logic [63:0]        rl;
  } sldc_root_t;

  typedef struct packed {
    logic             deg;
    logic             done;
    logic [63:0]      r;
    logic [61:0]      den;
    logic [RES_W-1:0] q;
  } sldc_div_t;

endpackage
`default_nettype wire

FILE: src/sldc_front.sv
// front stages: surface point, normal and light vector, block scaling
// depends on sldc_pkg
`default_nettype none
module sldc_front import sldc_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               i_valid,
  input  wire sldc_in_t           i_data,
  input  wire logic [2:0][31:0]   i_light,
  output logic                    o_valid,
  output sldc_vec_t               o_vec
);

  localparam logic [64:0] RND = (65'd1 << COORD_FRAC_BITS) - 65'd1;

  logic [2:0][31:0] dir, ctr, mag1;
  logic [2:0][63:0] prod1;

  logic             v1_r;
  logic [2:0][63:0] p1_r;
  logic [2:0]       n1_r;
  logic [2:0][31:0] c1_r;

  logic [2:0][33:0] nv2_nxt, lv2_nxt;
  logic             v2_r;
  logic [2:0][33:0] nv2_r, lv2_r;

  logic [2:0][33:0] nm3_nxt, lm3_nxt;
  logic [2:0]       ns3_nxt, ls3_nxt;
  logic [33:0]      nor3, lor3;
  logic [5:0]       nlead, llead;
  logic             nrt_nxt, lrt_nxt;
  logic [4:0]       namt_nxt, lamt_nxt;
  logic             v3_r, nz3_r, lz3_r, nrt3_r, lrt3_r;
  logic [4:0]       namt3_r, lamt3_r;
  logic [2:0][33:0] nm3_r, lm3_r;
  logic [2:0]       ns3_r, ls3_r;

  sldc_vec_t        vec_nxt;
  logic             v4_r;
  sldc_vec_t        vec4_r;

  assign dir = {i_data.ray_dir_z, i_data.ray_dir_y, i_data.ray_dir_x};
  assign ctr = {i_data.center_z, i_data.center_y, i_data.center_x};

  // stage 1: exact products of distance and direction magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i]  = dir[i][31] ? 32'(-dir[i]) : dir[i];
      prod1[i] = {32'd0, i_data.hit_distance} * {32'd0, mag1[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= i_valid;
    p1_r <= prod1;
    for (int i = 0; i < 3; i++) n1_r[i] <= dir[i][31];
    c1_r <= ctr;
  end

  // stage 2: floor shift, saturate, differences
  always_comb begin
    logic [64:0] sh;
    logic [31:0] s;
    for (int i = 0; i < 3; i++) begin
      sh = ({1'b0, p1_r[i]} + (n1_r[i] ? RND : 65'd0)) >> COORD_FRAC_BITS;
      if (n1_r[i]) s = (sh > 65'h80000000) ? 32'h80000000 : 32'(-sh[31:0]);
      else         s = (sh > 65'h7FFFFFFF) ? 32'h7FFFFFFF : sh[31:0];
      nv2_nxt[i] = {{2{c1_r[i][31]}}, c1_r[i]} - {{2{s[31]}}, s};
      lv2_nxt[i] = {{2{s[31]}}, s} - {{2{i_light[i][31]}}, i_light[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    nv2_r <= nv2_nxt;
    lv2_r <= lv2_nxt;
  end

  // stage 3: sign and magnitude, leading one of the largest component
  always_comb begin
    nor3  = '0;
    lor3  = '0;
    nlead = '0;
    llead = '0;
    for (int i = 0; i < 3; i++) begin
      ns3_nxt[i] = nv2_r[i][33];
      ls3_nxt[i] = lv2_r[i][33];
      nm3_nxt[i] = nv2_r[i][33] ? 34'(-nv2_r[i]) : nv2_r[i];
      lm3_nxt[i] = lv2_r[i][33] ? 34'(-lv2_r[i]) : lv2_r[i];
      nor3 = nor3 | nm3_nxt[i];
      lor3 = lor3 | lm3_nxt[i];
    end
    // the or of the magnitudes has its top bit where the maximum does
    for (int b = 0; b < 34; b++) begin
      if (nor3[b]) nlead = 6'(b);
      if (lor3[b]) llead = 6'(b);
    end
    nrt_nxt  = nlead > 6'd29;
    lrt_nxt  = llead > 6'd29;
    namt_nxt = nrt_nxt ? 5'(nlead - 6'd29) : 5'(6'd29 - nlead);
    lamt_nxt = lrt_nxt ? 5'(llead - 6'd29) : 5'(6'd29 - llead);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    nz3_r   <= nor3 == '0;
    lz3_r   <= lor3 == '0;
    nrt3_r  <= nrt_nxt;
    lrt3_r  <= lrt_nxt;
    namt3_r <= namt_nxt;
    lamt3_r <= lamt_nxt;
    nm3_r   <= nm3_nxt;
    lm3_r   <= lm3_nxt;
    ns3_r   <= ns3_nxt;
    ls3_r   <= ls3_nxt;
  end

  // stage 4: shift into [2^29, 2^30), right shifts truncate
  always_comb begin
    logic [33:0] tn, tl;
    vec_nxt.deg = nz3_r | lz3_r;
    vec_nxt.nsg = ns3_r;
    vec_nxt.lsg = ls3_r;
    for (int i = 0; i < 3; i++) begin
      tn = nrt3_r ? (nm3_r[i] >> namt3_r) : (nm3_r[i] << namt3_r);
      tl = lrt3_r ? (lm3_r[i] >> lamt3_r) : (lm3_r[i] << lamt3_r);
      vec_nxt.nm[i] = tn[29:0];
      vec_nxt.lm[i] = tl[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    vec4_r <= vec_nxt;
  end

  assign o_valid = v4_r;
  assign o_vec   = vec4_r;

endmodule
`default_nettype wire

FILE: src/sldc_dot.sv
// dot product and squared norms of the scaled vectors, two stages
// depends on sldc_pkg
`default_nettype none
module sldc_dot import sldc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      i_valid,
  input  wire sldc_vec_t i_vec,
  output logic           o_valid,
  output sldc_sums_t     o_sums
);

  logic             v1_r, deg1_r;
  logic [2:0]       neg1_r;
  logic [2:0][59:0] pr1_r, nq1_r, lq1_r;
  sldc_sums_t       sums_nxt;
  logic             v2_r;
  sldc_sums_t       sums2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= i_valid;
    deg1_r <= i_vec.deg;
    neg1_r <= i_vec.nsg ^ i_vec.lsg;
    for (int i = 0; i < 3; i++) begin
      pr1_r[i] <= {30'd0, i_vec.nm[i]} * {30'd0, i_vec.lm[i]};
      nq1_r[i] <= {30'd0, i_vec.nm[i]} * {30'd0, i_vec.nm[i]};
      lq1_r[i] <= {30'd0, i_vec.lm[i]} * {30'd0, i_vec.lm[i]};
    end
  end

  always_comb begin
    logic signed [63:0] t;
    sums_nxt.deg = deg1_r;
    sums_nxt.dot = '0;
    sums_nxt.n2  = '0;
    sums_nxt.l2  = '0;
    for (int i = 0; i < 3; i++) begin
      t = $signed({4'd0, pr1_r[i]});
      sums_nxt.dot = neg1_r[i] ? sums_nxt.dot - t : sums_nxt.dot + t;
      sums_nxt.n2  = sums_nxt.n2 + {4'd0, nq1_r[i]};
      sums_nxt.l2  = sums_nxt.l2 + {4'd0, lq1_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    sums2_r <= sums_nxt;
  end

  assign o_valid = v2_r;
  assign o_sums  = sums2_r;

endmodule
`default_nettype wire

FILE: src/sldc_root_step.sv
// one digit of both integer square roots, registered
// depends on sldc_pkg
`default_nettype none
module sldc_root_step import sldc_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       i_valid,
  input  wire sldc_root_t i_d,
  output logic            o_valid,
  output sldc_root_t      o_d
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  sldc_root_t d_nxt;
  logic       v_r;
  sldc_root_t d_r;

  always_comb begin
    logic [63:0] tn, tl;
    d_nxt = i_d;
    tn = i_d.rn + BIT;
    tl = i_d.rl + BIT;
    if (i_d.xn >= tn) begin
      d_nxt.xn = i_d.xn - tn;
      d_nxt.rn = (i_d.rn >> 1) + BIT;
    end else begin
      d_nxt.rn = i_d.rn >> 1;
    end
    if (i_d.xl >= tl) begin
      d_nxt.xl = i_d.xl - tl;
      d_nxt.rl = (i_d.rl >> 1) + BIT;
    end else begin
      d_nxt.rl = i_d.rl >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= i_valid;
    d_r <= d_nxt;
  end

  assign o_valid = v_r;
  assign o_d     = d_r;

endmodule
`default_nettype wire

FILE: src/sldc_div_step.sv
// one quotient bit of the restoring division, registered
// depends on sldc_pkg
`default_nettype none
module sldc_div_step import sldc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      i_valid,
  input  wire sldc_div_t i_d,
  output logic           o_valid,
  output sldc_div_t      o_d
);

  sldc_div_t d_nxt;
  logic      v_r;
  sldc_div_t d_r;

  always_comb begin
    logic [63:0] r2;
    d_nxt = i_d;
    r2    = i_d.r << 1;
    // clamped and zero results pass untouched
    if (!i_d.done) begin
      d_nxt.q = i_d.q << 1;
      d_nxt.r = r2;
      if (r2 >= {2'd0, i_d.den}) begin
        d_nxt.r    = r2 - {2'd0, i_d.den};
        d_nxt.q[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= i_valid;
    d_r <= d_nxt;
  end

  assign o_valid = v_r;
  assign o_d     = d_r;

endmodule
`default_nettype wire

FILE: src/sphere_lambert_diffuse_cosine.sv
// Lambert diffuse cosine for ray hits on a sphere, fully pipelined. One hit
// is taken every clock cycle; busy is never raised. Each result appears on
// out_data with out_valid high for one cycle, after 4 front stages, 2 dot
// stages, 32 square-root digit stages, one denominator multiply, one
// division setup and 16 quotient-bit stages.
// The receiver must take every result as it comes. Light position
// registers are written through cfg_we / cfg_index / cfg_wdata; the user
// must do so only while the pipeline is empty, which the block does not enforce.
// depends on sldc_pkg, the step modules and the assertion macro header
`default_nettype none
`include "sphere_lambert_diffuse_cosine_assert.svh"
module sphere_lambert_diffuse_cosine import sldc_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire sldc_in_t    in_data,
  output logic             out_valid,
  output sldc_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;
  localparam int LATENCY = FRONT_STAGES + DOT_STAGES + ROOT_STAGES + DIV_STAGES;
  localparam logic [RES_W-1:0] ONE = RES_W'(1) << RESULT_FRAC_BITS;

  logic [2:0][31:0] light_r;
  logic             in_fire;

  logic       fr_valid;
  sldc_vec_t  fr_vec;
  logic       dt_valid;
  sldc_sums_t dt_sums;

  logic       rv [0:ROOT_STAGES];
  sldc_root_t rd [0:ROOT_STAGES];

  logic        den_v_r, den_deg_r;
  logic signed [63:0] den_dot_r;
  logic [61:0] den_r;

  sldc_div_t   init_nxt;
  logic        dv [0:RESULT_FRAC_BITS];
  sldc_div_t   dd [0:RESULT_FRAC_BITS];
  logic        init_v_r;
  sldc_div_t   init_r;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_X: light_r[0] <= cfg_wdata;
        REG_LIGHT_Y: light_r[1] <= cfg_wdata;
        REG_LIGHT_Z: light_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sldc_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_fire),
    .i_data  (in_data),
    .i_light (light_r),
    .o_valid (fr_valid),
    .o_vec   (fr_vec)
  );

  sldc_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (fr_valid),
    .i_vec   (fr_vec),
    .o_valid (dt_valid),
    .o_sums  (dt_sums)
  );

  assign rv[0] = dt_valid;
  assign rd[0] = '{deg: dt_sums.deg, dot: dt_sums.dot, xn: dt_sums.n2, rn: 64'd0,
                   xl: dt_sums.l2, rl: 64'd0};

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
    sldc_root_step #(.STEP(k)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (rv[k]),
      .i_d     (rd[k]),
      .o_valid (rv[k+1]),
      .o_d     (rd[k+1])
    );
  end

  // product of the two lengths, each below 2^31
  always_ff @(posedge clk) begin
    if (!rst_n) den_v_r <= 1'b0;
    else        den_v_r <= rv[ROOT_STAGES];
    den_deg_r <= rd[ROOT_STAGES].deg;
    den_dot_r <= rd[ROOT_STAGES].dot;
    den_r     <= {31'd0, rd[ROOT_STAGES].rn[30:0]} * {31'd0, rd[ROOT_STAGES].rl[30:0]};
  end

  // facing away, zero vector and the clamp to one settle here
  always_comb begin
    init_nxt.deg  = den_deg_r;
    init_nxt.den  = den_r;
    init_nxt.r    = den_dot_r;
    init_nxt.q    = '0;
    init_nxt.done = 1'b0;
    if (den_deg_r || den_dot_r <= 64'sd0) begin
      init_nxt.done = 1'b1;
    end else if (den_dot_r >= $signed({2'd0, den_r})) begin
      init_nxt.done = 1'b1;
      init_nxt.q    = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) init_v_r <= 1'b0;
    else        init_v_r <= den_v_r;
    init_r <= init_nxt;
  end

  assign dv[0] = init_v_r;
  assign dd[0] = init_r;

  for (genvar k = 0; k < RESULT_FRAC_BITS; k++) begin : g_div
    sldc_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (dv[k]),
      .i_d     (dd[k]),
      .o_valid (dv[k+1]),
      .o_d     (dd[k+1])
    );
  end

  assign out_valid               = dv[RESULT_FRAC_BITS];
  assign out_data.diffuse_factor = dd[RESULT_FRAC_BITS].q;
  assign out_data.degenerate     = dd[RESULT_FRAC_BITS].deg;

  `SLDC_ASSERT_IMP(a_deg_zero, clk, rst_n, out_valid && out_data.degenerate, out_data.diffuse_factor == '0, "degenerate beat with nonzero factor")
  `SLDC_ASSERT_IMP(a_at_most_one, clk, rst_n, out_valid, out_data.diffuse_factor <= ONE, "factor above one")
  `SLDC_ASSERT_IMP(a_latency, clk, rst_n, 1'b1, out_valid == $past(in_fire && rst_n, LATENCY), "result beat not matching start beat")
  `SLDC_ASSERT_NXT(a_clamp_done, clk, rst_n, den_v_r && !den_deg_r && den_dot_r >= $signed({2'd0, den_r}), init_r.done && init_r.q == ONE, "clamp to one lost")

endmodule
`default_nettype wire

FILE: test/tb_sphere_lambert_diffuse_cosine.sv
// testbench for the sphere diffuse cosine pipeline: random and directed hits
// checked against a behavioral cosine predictor, four light positions
// depends on sldc_pkg and sphere_lambert_diffuse_cosine
`timescale 1ns / 1ps
module tb_sphere_lambert_diffuse_cosine;
  import sldc_pkg::*;

  localparam int LIGHT_X = 0;
  localparam int LIGHT_Y = 1;
  localparam int LIGHT_Z = 2;
  localparam int LIGHT_NONE = 3;
  localparam int PIPE_LAT = 56;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sldc_in_t in_data = '0;
  logic out_valid;
  sldc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  sphere_lambert_diffuse_cosine i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sldc_in_t hit_queue[$];
  sldc_out_t cosine_queue[$];
  logic signed [63:0] light[3];
  int send_idle_pct = 0;
  int mismatches = 0;
  longint cycles = 0;
  bit driver_hold = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] surface_coord(logic [31:0] d,
                                                       logic signed [31:0] r);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = $signed({96'd0, d}) * $signed({{96{r[31]}}, r});
    q = p >>> 16;
    if (q > 128'sh7FFFFFFF) q = 128'sh7FFFFFFF;
    if (q < -128'sh80000000) q = -128'sh80000000;
    return q[63:0];
  endfunction

  function automatic bit block_scale(logic signed [63:0] v[3], output bit sg[3],
                                     output logic [63:0] mg[3]);
    logic [63:0] mx;
    int rs;
    int ls;
    mx = 0;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) begin
      sg[i] = v[i] < 0;
      mg[i] = sg[i] ? -v[i] : v[i];
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= 64'd1 << 30) begin mx >>= 1; rs++; end
    while (mx < 64'd1 << 29) begin mx <<= 1; ls++; end
    for (int i = 0; i < 3; i++) mg[i] = (mg[i] >> rs) << ls;
    return 1'b1;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic sldc_out_t diffuse_cosine(sldc_in_t h);
    logic signed [63:0] nv[3];
    logic signed [63:0] lv[3];
    logic signed [31:0] dir[3];
    logic signed [31:0] ctr[3];
    bit ns[3];
    bit ls[3];
    logic [63:0] nm[3];
    logic [63:0] lm[3];
    logic signed [63:0] s;
    logic signed [63:0] dot;
    logic [63:0] n2;
    logic [63:0] l2;
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] p;
    logic [RES_W-1:0] q;
    sldc_out_t o;
    dir = '{h.ray_dir_x, h.ray_dir_y, h.ray_dir_z};
    ctr = '{h.center_x, h.center_y, h.center_z};
    for (int i = 0; i < 3; i++) begin
      s = surface_coord(h.hit_distance, dir[i]);
      nv[i] = ctr[i] - s;
      lv[i] = s - light[i];
    end
    o = '0;
    if (!block_scale(nv, ns, nm) || !block_scale(lv, ls, lm)) begin
      o.degenerate = 1'b1;
      return o;
    end
    dot = 0;
    n2 = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      p = nm[i] * lm[i];
      dot += (ns[i] != ls[i]) ? -$signed(p) : $signed(p);
      n2 += nm[i] * nm[i];
      l2 += lm[i] * lm[i];
    end
    q = 0;
    if (dot > 0) begin
      den = int_sqrt(n2) * int_sqrt(l2);
      if (dot >= den) begin
        q = 1 << RESULT_FRAC_BITS;
      end else begin
        r = dot;
        for (int i = 0; i < RESULT_FRAC_BITS; i++) begin
          r <<= 1;
          q <<= 1;
          if (r >= den) begin
            r -= den;
            q |= 1;
          end
        end
      end
    end
    o.diffuse_factor = q;
    return o;
  endfunction

  // driver: predicts at acceptance so queue order matches the pipe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) cosine_queue.push_back(diffuse_cosine(in_data));
      if ((!start || !busy) && !driver_hold && hit_queue.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= hit_queue.pop_front();
        start <= 1'b1;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cosine_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        sldc_out_t e;
        e = cosine_queue.pop_front();
        if (e.diffuse_factor !== out_data.diffuse_factor ||
            e.degenerate !== out_data.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp factor %h deg %b, got factor %h deg %b",
                     e.diffuse_factor, e.degenerate,
                     out_data.diffuse_factor, out_data.degenerate);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_light(int idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[1:0];
    cfg_wdata <= v;
    if (idx < 3) light[idx] = $signed(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    driver_hold = 1'b0;
    while (hit_queue.size() > 0 || start || cosine_queue.size() > 0) @(posedge clk);
    driver_hold = 1'b1;
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed(32'($urandom_range(40))) - 20 <<< 16 | $urandom_range(255);
    endcase
  endfunction

  function automatic sldc_in_t rand_hit();
    sldc_in_t h;
    h.hit_distance = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h80000);
    h.ray_dir_x = rand_coord();
    h.ray_dir_y = rand_coord();
    h.ray_dir_z = rand_coord();
    h.center_x = rand_coord();
    h.center_y = rand_coord();
    h.center_z = rand_coord();
    return h;
  endfunction

  initial begin
    sldc_in_t h;
    light = '{0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: degenerate normal, degenerate light, facing away, extremes
    h = '0;
    hit_queue.push_back(h);
    h.center_x = 32'h10000;
    hit_queue.push_back(h);
    h = '{32'h10000, 32'h10000, 0, 0, 32'h10000, 0, 0};
    hit_queue.push_back(h);
    h = '{32'h10000, 32'h10000, 0, 0, 32'h30000, 0, 0};
    hit_queue.push_back(h);
    h = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    hit_queue.push_back(h);
    h = '{32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    hit_queue.push_back(h);
    h = '{32'h00000001, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 1, 2, 3};
    hit_queue.push_back(h);
    for (int i = 0; i < 10; i++) hit_queue.push_back(rand_hit());
    drain();
    write_light(LIGHT_X, 32'h00030000);
    write_light(LIGHT_Y, 32'hFFFE0000);
    write_light(LIGHT_Z, 32'h00050000);
    write_light(LIGHT_NONE, 32'hDEADBEEF);
    h = '{32'h10000, 32'h30000, 32'hFFFE0000, 32'h50000, 0, 0, 0};
    hit_queue.push_back(h);
    send_idle_pct = 17;
    for (int i = 0; i < 430; i++) hit_queue.push_back(rand_hit());
    drain();
    write_light(LIGHT_X, 32'h7FFFFFFF);
    write_light(LIGHT_Y, 32'h80000000);
    write_light(LIGHT_Z, 32'h7FFFFFFF);
    send_idle_pct = 81;
    for (int i = 0; i < 430; i++) hit_queue.push_back(rand_hit());
    drain();
    write_light(LIGHT_X, $urandom());
    write_light(LIGHT_Y, 32'h80000000);
    write_light(LIGHT_Z, {16'($urandom_range(1) ? 16'hFFFF : 0), 16'($urandom())});
    send_idle_pct = 0;
    for (int i = 0; i < 430; i++) hit_queue.push_back(rand_hit());
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+src
src/sldc_pkg.sv
src/sldc_front.sv
src/sldc_dot.sv
src/sldc_root_step.sv
src/sldc_div_step.sv
src/sphere_lambert_diffuse_cosine.sv
test/tb_sphere_lambert_diffuse_cosine.sv
